/* rtl/core/cbmf_pkg.sv */
// ----------------------------------------------------------------------------
// Clamped box mean filter package
// Shared sizes, register indexes and the structs passed between the blocks.
// ----------------------------------------------------------------------------
package cbmf_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int PIXEL_BITS   = 16;

  localparam int PIX_IN_BITS  = 16;
  localparam int PIX_USE_BITS = (PIXEL_BITS < PIX_IN_BITS) ? PIXEL_BITS : PIX_IN_BITS;
  localparam int POS_IN_BITS  = 8;
  localparam int RADIUS_BITS  = 8;
  localparam int SIZE_BITS    = 9;

  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS    = COL_BITS + ROW_BITS;
  localparam int STORE_DEPTH  = 1 << ADDR_BITS;

  localparam int ENTRY_BITS   = 32;
  localparam int RSUM_BITS    = 24;
  localparam int AREA_BITS    = COL_BITS + ROW_BITS + 1;
  localparam int FRAC_BITS    = 8;
  localparam int MEAN_BITS    = 24;
  localparam int DIVD_BITS    = ENTRY_BITS + FRAC_BITS;
  localparam int AREA_OUT_BITS = 17;
  localparam logic [AREA_OUT_BITS-1:0] AREA_OUT_MAX = '1;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [SIZE_BITS-1:0]   width_eff;
    logic [SIZE_BITS-1:0]   height_eff;
    logic [RADIUS_BITS-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [ENTRY_BITS-1:0] sum;
    logic [AREA_BITS-1:0]  area;
  } div_req_t;

  typedef struct packed {
    logic                 valid;
    logic [MEAN_BITS-1:0] mean;
    logic [AREA_BITS-1:0] area;
  } div_rsp_t;

endpackage

/* rtl/core/cbmf_div.sv */
// ----------------------------------------------------------------------------
// Mean divider
// Restoring divider, one quotient bit per cycle, with early saturation.
// ----------------------------------------------------------------------------
module cbmf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cbmf_pkg::div_req_t req,
  input  logic              take,
  output logic              busy,
  output cbmf_pkg::div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(cbmf_pkg::MEAN_BITS + 1);
  localparam int SAT_PAD  = cbmf_pkg::AREA_BITS + cbmf_pkg::MEAN_BITS - cbmf_pkg::DIVD_BITS;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } dstate_t;

  dstate_t                            state_r, state_nxt;
  logic [cbmf_pkg::AREA_BITS-1:0]     rem_r;
  logic [cbmf_pkg::AREA_BITS-1:0]     area_r;
  logic [cbmf_pkg::MEAN_BITS-1:0]     dq_r;
  logic [CNT_BITS-1:0]                cnt_r;

  logic [cbmf_pkg::DIVD_BITS-1:0]     dividend;
  logic                               sat;
  logic [cbmf_pkg::AREA_BITS:0]       trial;
  logic                               ge;
  logic [cbmf_pkg::AREA_BITS-1:0]     rem_nxt;

  assign dividend = {req.sum, {cbmf_pkg::FRAC_BITS{1'b0}}};
  assign sat = ({{SAT_PAD{1'b0}}, dividend} >=
                {req.area, {cbmf_pkg::MEAN_BITS{1'b0}}});

  assign trial   = {rem_r, dq_r[cbmf_pkg::MEAN_BITS-1]};
  assign ge      = (trial >= {1'b0, area_r});
  assign rem_nxt = ge ? cbmf_pkg::AREA_BITS'(trial - {1'b0, area_r})
                      : cbmf_pkg::AREA_BITS'(trial);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          state_nxt = sat ? D_DONE : D_RUN;
        end
      end
      D_RUN: begin
        if (cnt_r == CNT_BITS'(1)) begin
          state_nxt = D_DONE;
        end
      end
      D_DONE: begin
        if (take) begin
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && req.start) begin
      area_r <= req.area;
      cnt_r  <= CNT_BITS'(cbmf_pkg::MEAN_BITS);
      if (sat) begin
        dq_r <= '1;
      end else begin
        dq_r  <= dividend[cbmf_pkg::MEAN_BITS-1:0];
        rem_r <= cbmf_pkg::AREA_BITS'(dividend >> cbmf_pkg::MEAN_BITS);
      end
    end else if (state_r == D_RUN) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[cbmf_pkg::MEAN_BITS-2:0], ge};
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  assign busy      = (state_r != D_IDLE);
  assign rsp.valid = (state_r == D_DONE);
  assign rsp.mean  = dq_r;
  assign rsp.area  = area_r;

endmodule

/* rtl/core/cbmf_integ.sv */
// ----------------------------------------------------------------------------
// Integral image store and sequencer
// Holds the integral image in a single-port memory, builds it from loads and
// gathers the four corner entries and the window area for queries.
// ----------------------------------------------------------------------------
module cbmf_integ (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 action,
  input  logic [cbmf_pkg::PIX_IN_BITS-1:0]     pixel_value,
  input  logic [cbmf_pkg::POS_IN_BITS-1:0]     query_col,
  input  logic [cbmf_pkg::POS_IN_BITS-1:0]     query_row,
  input  cbmf_pkg::cfg_t                       cfg,
  output logic                                 busy,
  output cbmf_pkg::div_req_t                   div_req
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LD_RD = 7'b0000010,
    S_LD_WR = 7'b0000100,
    S_Q_SET = 7'b0001000,
    S_Q_RD  = 7'b0010000,
    S_Q_ACC = 7'b0100000,
    S_Q_OUT = 7'b1000000
  } state_t;

  localparam logic [1:0] CRN_BR = 2'd0;
  localparam logic [1:0] CRN_TR = 2'd1;
  localparam logic [1:0] CRN_BL = 2'd2;
  localparam logic [1:0] CRN_TL = 2'd3;

  state_t                              state_r, state_nxt;
  logic [cbmf_pkg::COL_BITS-1:0]       col_r;
  logic [cbmf_pkg::ROW_BITS-1:0]       row_r;
  logic [cbmf_pkg::RSUM_BITS-1:0]      rsum_r;
  logic [cbmf_pkg::POS_IN_BITS-1:0]    qcol_r;
  logic [cbmf_pkg::POS_IN_BITS-1:0]    qrow_r;
  logic [cbmf_pkg::COL_BITS-1:0]       c0_r, c1_r;
  logic [cbmf_pkg::ROW_BITS-1:0]       r0_r, r1_r;
  logic [cbmf_pkg::AREA_BITS-1:0]      area_r;
  logic [cbmf_pkg::ENTRY_BITS-1:0]     acc_r;
  logic [1:0]                          cnt_r;
  logic                                pend_use_r;
  logic                                pend_neg_r;
  logic [cbmf_pkg::ENTRY_BITS-1:0]     rd_data_r;
  logic [cbmf_pkg::ENTRY_BITS-1:0]     mem [cbmf_pkg::STORE_DEPTH];

  logic [cbmf_pkg::ADDR_BITS-1:0]      mem_addr;
  logic                                mem_we;
  logic [cbmf_pkg::ENTRY_BITS-1:0]     mem_wdata;
  logic [cbmf_pkg::ROW_BITS-1:0]       crn_row;
  logic [cbmf_pkg::COL_BITS-1:0]       crn_col;
  logic                                crn_use;
  logic                                crn_neg;
  logic [cbmf_pkg::COL_BITS:0]         col_inc;
  logic [cbmf_pkg::ROW_BITS:0]         row_inc;
  logic                                col_wrap;
  logic                                row_wrap;
  logic [cbmf_pkg::COL_BITS:0]         win_w;
  logic [cbmf_pkg::ROW_BITS:0]         win_h;

  function automatic logic [31:0] clamp_lo(
    input logic [cbmf_pkg::POS_IN_BITS-1:0] c,
    input logic [cbmf_pkg::RADIUS_BITS-1:0] r,
    input logic [cbmf_pkg::SIZE_BITS-1:0]   sz
  );
    logic [31:0] d;
    logic [31:0] lim;
    d   = 32'(c) - 32'(r);
    lim = 32'(sz) - 32'd1;
    if (c < r) begin
      return 32'd0;
    end else if (d > lim) begin
      return lim;
    end else begin
      return d;
    end
  endfunction

  function automatic logic [31:0] clamp_hi(
    input logic [cbmf_pkg::POS_IN_BITS-1:0] c,
    input logic [cbmf_pkg::RADIUS_BITS-1:0] r,
    input logic [cbmf_pkg::SIZE_BITS-1:0]   sz
  );
    logic [31:0] s;
    logic [31:0] lim;
    s   = 32'(c) + 32'(r);
    lim = 32'(sz) - 32'd1;
    return (s > lim) ? lim : s;
  endfunction

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign col_wrap = (32'(col_inc) >= 32'(cfg.width_eff));
  assign row_wrap = (32'(row_inc) >= 32'(cfg.height_eff));

  assign win_w = {1'b0, c1_r} - {1'b0, c0_r} + 1'b1;
  assign win_h = {1'b0, r1_r} - {1'b0, r0_r} + 1'b1;

  always_comb begin
    crn_row = r1_r;
    crn_col = c1_r;
    crn_use = 1'b1;
    crn_neg = 1'b0;
    unique case (cnt_r)
      CRN_BR: begin
        crn_row = r1_r;
        crn_col = c1_r;
        crn_use = 1'b1;
        crn_neg = 1'b0;
      end
      CRN_TR: begin
        crn_row = r0_r - 1'b1;
        crn_col = c1_r;
        crn_use = (r0_r != '0);
        crn_neg = 1'b1;
      end
      CRN_BL: begin
        crn_row = r1_r;
        crn_col = c0_r - 1'b1;
        crn_use = (c0_r != '0);
        crn_neg = 1'b1;
      end
      CRN_TL: begin
        crn_row = r0_r - 1'b1;
        crn_col = c0_r - 1'b1;
        crn_use = (r0_r != '0) && (c0_r != '0);
        crn_neg = 1'b0;
      end
      default: begin
        crn_use = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {crn_row, crn_col};
    mem_wdata = cbmf_pkg::ENTRY_BITS'(rsum_r) +
                ((row_r == '0) ? '0 : rd_data_r);
    if (state_r == S_LD_RD) begin
      mem_addr = {row_r - 1'b1, col_r};
    end else if (state_r == S_LD_WR) begin
      mem_addr = {row_r, col_r};
      mem_we   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (action == cbmf_pkg::ACT_LOAD) ? S_LD_RD : S_Q_SET;
        end
      end
      S_LD_RD: state_nxt = S_LD_WR;
      S_LD_WR: state_nxt = S_IDLE;
      S_Q_SET: state_nxt = S_Q_RD;
      S_Q_RD: begin
        if (cnt_r == CRN_TL) begin
          state_nxt = S_Q_ACC;
        end
      end
      S_Q_ACC: state_nxt = S_Q_OUT;
      S_Q_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      rsum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start && action == cbmf_pkg::ACT_LOAD) begin
        rsum_r <= rsum_r + cbmf_pkg::RSUM_BITS'(pixel_value[cbmf_pkg::PIX_USE_BITS-1:0]);
      end else if (state_r == S_LD_WR) begin
        if (col_wrap) begin
          col_r  <= '0;
          rsum_r <= '0;
          row_r  <= row_wrap ? '0 : cbmf_pkg::ROW_BITS'(row_inc);
        end else begin
          col_r <= cbmf_pkg::COL_BITS'(col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      qcol_r <= query_col;
      qrow_r <= query_row;
    end
    if (state_r == S_Q_SET) begin
      c0_r       <= cbmf_pkg::COL_BITS'(clamp_lo(qcol_r, cfg.radius, cfg.width_eff));
      c1_r       <= cbmf_pkg::COL_BITS'(clamp_hi(qcol_r, cfg.radius, cfg.width_eff));
      r0_r       <= cbmf_pkg::ROW_BITS'(clamp_lo(qrow_r, cfg.radius, cfg.height_eff));
      r1_r       <= cbmf_pkg::ROW_BITS'(clamp_hi(qrow_r, cfg.radius, cfg.height_eff));
      acc_r      <= '0;
      cnt_r      <= CRN_BR;
      pend_use_r <= 1'b0;
      pend_neg_r <= 1'b0;
    end
    if (state_r == S_Q_RD || state_r == S_Q_ACC) begin
      if (pend_use_r) begin
        acc_r <= pend_neg_r ? (acc_r - rd_data_r) : (acc_r + rd_data_r);
      end
    end
    if (state_r == S_Q_RD) begin
      pend_use_r <= crn_use;
      pend_neg_r <= crn_neg;
      cnt_r      <= cnt_r + 1'b1;
      area_r     <= cbmf_pkg::AREA_BITS'(win_w * win_h);
    end
    if (state_r == S_Q_ACC) begin
      pend_use_r <= 1'b0;
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign div_req.start = (state_r == S_Q_OUT);
  assign div_req.sum   = acc_r;
  assign div_req.area  = area_r;

endmodule

/* rtl/core/clamped_box_mean_filter.sv */
// ----------------------------------------------------------------------------
// Clamped box mean filter
// Builds an integral image from raster-order pixel loads and answers window
// mean queries over a square window clamped to the image.
// ----------------------------------------------------------------------------
// A load transaction is taken, then reads the entry above from the single-port
// integral memory and then writes the new entry. A query transaction passes
// through the memory sequencer (setup, four corner reads through the one
// memory port, accumulate, hand off) and then through the bit-serial divider,
// which skips its bit-serial run when the mean saturates. A finished mean
// waits in the output register, and the next transaction is taken while it
// waits. The memory is not cleared after reset; a query must only cover
// entries already loaded.
module clamped_box_mean_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic [cbmf_pkg::PIX_IN_BITS-1:0]      in_pixel_value,
  input  logic [cbmf_pkg::POS_IN_BITS-1:0]      in_query_col,
  input  logic [cbmf_pkg::POS_IN_BITS-1:0]      in_query_row,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cbmf_pkg::MEAN_BITS-1:0]        out_mean_value,
  output logic [cbmf_pkg::AREA_OUT_BITS-1:0]    out_window_area,
  input  logic                                  cfg_wr_en,
  input  logic [cbmf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cbmf_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  logic [cbmf_pkg::SIZE_BITS-1:0]      width_r;
  logic [cbmf_pkg::SIZE_BITS-1:0]      height_r;
  logic [cbmf_pkg::RADIUS_BITS-1:0]    radius_r;
  logic                                out_valid_r;
  logic [cbmf_pkg::MEAN_BITS-1:0]      out_mean_r;
  logic [cbmf_pkg::AREA_OUT_BITS-1:0]  out_area_r;

  cbmf_pkg::cfg_t      cfg;
  cbmf_pkg::div_req_t  div_req;
  cbmf_pkg::div_rsp_t  div_rsp;
  logic                integ_busy;
  logic                div_busy;
  logic                start;
  logic                take;

  function automatic logic [cbmf_pkg::SIZE_BITS-1:0] eff_size(
    input logic [cbmf_pkg::SIZE_BITS-1:0] v,
    input int                             maxv
  );
    if (v == '0) begin
      return cbmf_pkg::SIZE_BITS'(1);
    end else if (32'(v) > 32'(maxv)) begin
      return cbmf_pkg::SIZE_BITS'(maxv);
    end else begin
      return v;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cbmf_pkg::SIZE_BITS'(256);
      height_r <= cbmf_pkg::SIZE_BITS'(256);
      radius_r <= cbmf_pkg::RADIUS_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cbmf_pkg::REG_IMAGE_WIDTH:   width_r  <= cfg_wdata;
        cbmf_pkg::REG_IMAGE_HEIGHT:  height_r <= cfg_wdata;
        cbmf_pkg::REG_WINDOW_RADIUS: radius_r <= cfg_wdata[cbmf_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.width_eff  = eff_size(width_r, cbmf_pkg::MAX_WIDTH);
  assign cfg.height_eff = eff_size(height_r, cbmf_pkg::MAX_HEIGHT);
  assign cfg.radius     = radius_r;

  assign in_stall = integ_busy | div_busy;
  assign start    = in_valid & ~in_stall;

  cbmf_integ u_integ (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .action      (in_action),
    .pixel_value (in_pixel_value),
    .query_col   (in_query_col),
    .query_row   (in_query_row),
    .cfg         (cfg),
    .busy        (integ_busy),
    .div_req     (div_req)
  );

  assign take = ~out_valid_r | ~out_stall;

  cbmf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .take  (take),
    .busy  (div_busy),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_rsp.valid && take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_rsp.valid && take) begin
      out_mean_r <= div_rsp.mean;
      out_area_r <= (32'(div_rsp.area) > 32'(cbmf_pkg::AREA_OUT_MAX))
                    ? cbmf_pkg::AREA_OUT_MAX
                    : cbmf_pkg::AREA_OUT_BITS'(div_rsp.area);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mean_value  = out_mean_r;
  assign out_window_area = out_area_r;

endmodule
